[src/lab_pkg.sv]
`default_nettype none
package lab_pkg;

    localparam longint unsigned WX = 64'd950456;
    localparam longint unsigned WY = 64'd1000000;
    localparam longint unsigned WZ = 64'd1088754;

    localparam int COEF_W = 20;
    localparam int T_W = 21;
    localparam int F_W = 22;
    localparam int REM_W = 3 * F_W;
    localparam int SQ_W = 2 * F_W;
    localparam int SUM_W = 30;
    localparam int ACC_W = 40;

    localparam logic [COEF_W-1:0] MXR = COEF_W'((((64'd412453 << 21) / WX) + 64'd1) >> 1);
    localparam logic [COEF_W-1:0] MXG = COEF_W'((((64'd357580 << 21) / WX) + 64'd1) >> 1);
    localparam logic [COEF_W-1:0] MXB = COEF_W'((((64'd180423 << 21) / WX) + 64'd1) >> 1);
    localparam logic [COEF_W-1:0] MYR = COEF_W'((((64'd212671 << 21) / WY) + 64'd1) >> 1);
    localparam logic [COEF_W-1:0] MYG = COEF_W'((((64'd715160 << 21) / WY) + 64'd1) >> 1);
    localparam logic [COEF_W-1:0] MYB = COEF_W'((((64'd72169 << 21) / WY) + 64'd1) >> 1);
    localparam logic [COEF_W-1:0] MZR = COEF_W'((((64'd19334 << 21) / WZ) + 64'd1) >> 1);
    localparam logic [COEF_W-1:0] MZG = COEF_W'((((64'd119193 << 21) / WZ) + 64'd1) >> 1);
    localparam logic [COEF_W-1:0] MZB = COEF_W'((((64'd950227 << 21) / WZ) + 64'd1) >> 1);

    localparam logic [29:0] RECIP_255 = 30'd538976289;
    localparam int RECIP_SH = 37;

    localparam logic [T_W-1:0] T_THRESH = T_W'((64'd8856 << 20) / 64'd1000000);
    localparam logic [18:0] K7 = 19'((((64'd7787 << 17) / 64'd1000) + 64'd1) >> 1);
    localparam logic [F_W-1:0] C16 = F_W'((((64'd16 << 21) / 64'd116) + 64'd1) >> 1);
    localparam logic [25:0] K903 = 26'((((64'd9033 << 17) / 64'd10) + 64'd1) >> 1);

    typedef logic [T_W-1:0] t_val_t;
    typedef logic [F_W-1:0] f_val_t;

endpackage
`default_nettype wire

[src/lab_matrix.sv]
`default_nettype none
module lab_matrix
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            v_in,
    input  wire logic [7:0]      red,
    input  wire logic [7:0]      green,
    input  wire logic [7:0]      blue,
    output logic                 v_out,
    output lab_pkg::t_val_t      t_x,
    output lab_pkg::t_val_t      t_y,
    output lab_pkg::t_val_t      t_z
);

    localparam int SW = lab_pkg::SUM_W;

    logic          v1_reg;
    logic          v2_reg;
    logic [SW-1:0] sx_reg;
    logic [SW-1:0] sy_reg;
    logic [SW-1:0] sz_reg;
    logic [SW-1:0] sx_next;
    logic [SW-1:0] sy_next;
    logic [SW-1:0] sz_next;
    logic [59:0]   qx;
    logic [59:0]   qy;
    logic [59:0]   qz;
    lab_pkg::t_val_t tx_reg;
    lab_pkg::t_val_t ty_reg;
    lab_pkg::t_val_t tz_reg;

    always_comb
    begin
        sx_next = SW'(lab_pkg::MXR) * SW'(red) + SW'(lab_pkg::MXG) * SW'(green)
                + SW'(lab_pkg::MXB) * SW'(blue) + SW'(127);
        sy_next = SW'(lab_pkg::MYR) * SW'(red) + SW'(lab_pkg::MYG) * SW'(green)
                + SW'(lab_pkg::MYB) * SW'(blue) + SW'(127);
        sz_next = SW'(lab_pkg::MZR) * SW'(red) + SW'(lab_pkg::MZG) * SW'(green)
                + SW'(lab_pkg::MZB) * SW'(blue) + SW'(127);
        qx = (60'(sx_reg) * 60'(lab_pkg::RECIP_255)) >> lab_pkg::RECIP_SH;
        qy = (60'(sy_reg) * 60'(lab_pkg::RECIP_255)) >> lab_pkg::RECIP_SH;
        qz = (60'(sz_reg) * 60'(lab_pkg::RECIP_255)) >> lab_pkg::RECIP_SH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sz_reg <= sz_next;
            tx_reg <= qx[lab_pkg::T_W-1:0];
            ty_reg <= qy[lab_pkg::T_W-1:0];
            tz_reg <= qz[lab_pkg::T_W-1:0];
        end
    end

    assign v_out = v2_reg;
    assign t_x = tx_reg;
    assign t_y = ty_reg;
    assign t_z = tz_reg;

endmodule
`default_nettype wire

[src/lab_cbrt_stage.sv]
`default_nettype none
module lab_cbrt_stage
#(
    parameter int K = 0
)
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [lab_pkg::REM_W-1:0] rem_in,
    input  wire logic [lab_pkg::F_W-1:0]   y_in,
    input  wire logic [lab_pkg::SQ_W-1:0]  ysq_in,
    output logic [lab_pkg::REM_W-1:0]      rem_out,
    output logic [lab_pkg::F_W-1:0]        y_out,
    output logic [lab_pkg::SQ_W-1:0]       ysq_out
);

    localparam int RW = lab_pkg::REM_W;
    localparam int BW = RW + 2;

    logic [BW-1:0]           base;
    logic [BW-1:0]           trial;
    logic                    take;
    logic [RW-1:0]           rem_reg;
    logic [RW-1:0]           rem_next;
    logic [lab_pkg::F_W-1:0] y_reg;
    logic [lab_pkg::F_W-1:0] y_next;
    logic [lab_pkg::SQ_W-1:0] ysq_reg;
    logic [lab_pkg::SQ_W-1:0] ysq_next;

    always_comb
    begin
        base = (BW'(ysq_in) << 3) + (BW'(ysq_in) << 2) + (BW'(y_in) << 2)
             + (BW'(y_in) << 1) + BW'(1);
        trial = base << (3 * K);
        take = BW'(rem_in) >= trial;
        rem_next = take ? RW'(BW'(rem_in) - trial) : rem_in;
        y_next = {y_in[lab_pkg::F_W-2:0], take};
        ysq_next = (ysq_in << 2) + (take ? ((lab_pkg::SQ_W'(y_in) << 2) + lab_pkg::SQ_W'(1))
                                         : lab_pkg::SQ_W'(0));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            y_reg <= y_next;
            ysq_reg <= ysq_next;
        end
    end

    assign rem_out = rem_reg;
    assign y_out = y_reg;
    assign ysq_out = ysq_reg;

endmodule
`default_nettype wire

[src/lab_cbrt_unit.sv]
`default_nettype none
module lab_cbrt_unit
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            v_in,
    input  wire lab_pkg::t_val_t t_in,
    output logic                 v_out,
    output lab_pkg::t_val_t      t_out,
    output lab_pkg::f_val_t      f_out
);

    localparam int N = lab_pkg::F_W;

    logic [lab_pkg::REM_W-1:0] rem_w [N+1];
    logic [lab_pkg::F_W-1:0]   y_w   [N+1];
    logic [lab_pkg::SQ_W-1:0]  ysq_w [N+1];
    lab_pkg::t_val_t           t_reg [N];
    logic [N-1:0]              v_reg;

    assign rem_w[0] = lab_pkg::REM_W'(t_in) << 40;
    assign y_w[0] = '0;
    assign ysq_w[0] = '0;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        lab_cbrt_stage #(.K(N - 1 - i)) u_stage
        (
            .clk(clk),
            .en(en),
            .rem_in(rem_w[i]),
            .y_in(y_w[i]),
            .ysq_in(ysq_w[i]),
            .rem_out(rem_w[i+1]),
            .y_out(y_w[i+1]),
            .ysq_out(ysq_w[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[N-2:0], v_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= t_in;
            for (int i = 1; i < N; i++)
            begin
                t_reg[i] <= t_reg[i-1];
            end
        end
    end

    assign v_out = v_reg[N-1];
    assign t_out = t_reg[N-1];
    assign f_out = y_w[N];

endmodule
`default_nettype wire

[src/lab_finish.sv]
`default_nettype none
module lab_finish
#(
    parameter int FRAC_BITS = 8
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            v_in,
    input  wire lab_pkg::t_val_t t_x,
    input  wire lab_pkg::t_val_t t_y,
    input  wire lab_pkg::t_val_t t_z,
    input  wire lab_pkg::f_val_t c_x,
    input  wire lab_pkg::f_val_t c_y,
    input  wire lab_pkg::f_val_t c_z,
    output logic                 v_out,
    output logic [14:0]          lightness,
    output logic signed [15:0]   green_red,
    output logic signed [15:0]   blue_yellow
);

    localparam int AW = lab_pkg::ACC_W;
    localparam int SH = 20 - FRAC_BITS;
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (SH - 1);
    localparam longint LMAX_RAW = 64'(100) << FRAC_BITS;
    localparam logic signed [AW-1:0] L_HI = (LMAX_RAW < 64'(32767)) ? AW'(LMAX_RAW)
                                                                    : AW'(32767);
    localparam logic signed [AW-1:0] C_HI = AW'(32767);
    localparam logic signed [AW-1:0] C_LO = -AW'(32768);

    logic [2:0]              v_reg;
    logic [33:0]             lin_x;
    logic [33:0]             lin_y;
    logic [33:0]             lin_z;
    logic [39:0]             llin_p;
    lab_pkg::f_val_t         fx;
    lab_pkg::f_val_t         fy;
    lab_pkg::f_val_t         fz;
    logic                    big_y_reg;
    lab_pkg::f_val_t         fy_reg;
    logic signed [23:0]      dxy_reg;
    logic signed [23:0]      dyz_reg;
    logic [23:0]             llin_reg;
    logic signed [AW-1:0]    l_reg;
    logic signed [AW-1:0]    a_reg;
    logic signed [AW-1:0]    b_reg;
    logic signed [AW-1:0]    l_next;
    logic signed [AW-1:0]    lr;
    logic signed [AW-1:0]    ar;
    logic signed [AW-1:0]    br;
    logic [14:0]             l_out_reg;
    logic signed [15:0]      a_out_reg;
    logic signed [15:0]      b_out_reg;

    always_comb
    begin
        lin_x = ((34'(lab_pkg::K7) * 34'(t_x[13:0]) + 34'(32768)) >> 16) + 34'(lab_pkg::C16);
        lin_y = ((34'(lab_pkg::K7) * 34'(t_y[13:0]) + 34'(32768)) >> 16) + 34'(lab_pkg::C16);
        lin_z = ((34'(lab_pkg::K7) * 34'(t_z[13:0]) + 34'(32768)) >> 16) + 34'(lab_pkg::C16);
        llin_p = (40'(lab_pkg::K903) * 40'(t_y[13:0]) + 40'(32768)) >> 16;
        fx = (t_x > lab_pkg::T_THRESH) ? c_x : lin_x[lab_pkg::F_W-1:0];
        fy = (t_y > lab_pkg::T_THRESH) ? c_y : lin_y[lab_pkg::F_W-1:0];
        fz = (t_z > lab_pkg::T_THRESH) ? c_z : lin_z[lab_pkg::F_W-1:0];
        l_next = big_y_reg ? (AW'(fy_reg) * AW'(116) - (AW'(16) <<< 20)) : AW'(llin_reg);
        lr = (l_reg + HALF) >>> SH;
        ar = (a_reg + HALF) >>> SH;
        br = (b_reg + HALF) >>> SH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], v_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_y_reg <= t_y > lab_pkg::T_THRESH;
            fy_reg <= fy;
            dxy_reg <= $signed({2'b00, fx}) - $signed({2'b00, fy});
            dyz_reg <= $signed({2'b00, fy}) - $signed({2'b00, fz});
            llin_reg <= llin_p[23:0];
            l_reg <= l_next;
            a_reg <= AW'(dxy_reg) * AW'(500);
            b_reg <= AW'(dyz_reg) * AW'(200);
            if (lr < 0)
            begin
                l_out_reg <= '0;
            end
            else if (lr > L_HI)
            begin
                l_out_reg <= L_HI[14:0];
            end
            else
            begin
                l_out_reg <= lr[14:0];
            end
            if (ar < C_LO)
            begin
                a_out_reg <= C_LO[15:0];
            end
            else if (ar > C_HI)
            begin
                a_out_reg <= C_HI[15:0];
            end
            else
            begin
                a_out_reg <= ar[15:0];
            end
            if (br < C_LO)
            begin
                b_out_reg <= C_LO[15:0];
            end
            else if (br > C_HI)
            begin
                b_out_reg <= C_HI[15:0];
            end
            else
            begin
                b_out_reg <= br[15:0];
            end
        end
    end

    assign v_out = v_reg[2];
    assign lightness = l_out_reg;
    assign green_red = a_out_reg;
    assign blue_yellow = b_out_reg;

endmodule
`default_nettype wire

[src/rgb_to_cielab_converter_unit.sv]
`default_nettype none
// Converts one linear 8-bit RGB pixel per clock into CIE L*a*b* (D65 white) with
// FRAC_BITS fractional bits; a new item is taken every cycle unless out_stall holds a
// finished item, and passes through two matrix stages, one cube-root stage per result
// bit (22 of them in each of three parallel chains, one per channel) and three output
// stages. When a finished item is held by out_stall the whole pipeline holds with it.
module rgb_to_cielab_converter_unit
#(
    parameter int FRAC_BITS = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [7:0]   red,
    input  wire logic [7:0]   green,
    input  wire logic [7:0]   blue,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [14:0]       lightness,
    output logic signed [15:0] green_red,
    output logic signed [15:0] blue_yellow
);

    logic            en;
    logic            v_m;
    logic            v_cx;
    logic            v_cy;
    logic            v_cz;
    lab_pkg::t_val_t tm_x;
    lab_pkg::t_val_t tm_y;
    lab_pkg::t_val_t tm_z;
    lab_pkg::t_val_t tc_x;
    lab_pkg::t_val_t tc_y;
    lab_pkg::t_val_t tc_z;
    lab_pkg::f_val_t c_x;
    lab_pkg::f_val_t c_y;
    lab_pkg::f_val_t c_z;
    logic            v_all;

    assign en = !(out_valid && out_stall);
    assign in_stall = !en;
    assign v_all = v_cx & v_cy & v_cz;

    lab_matrix u_matrix
    (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .v_in(in_valid),
        .red(red),
        .green(green),
        .blue(blue),
        .v_out(v_m),
        .t_x(tm_x),
        .t_y(tm_y),
        .t_z(tm_z)
    );

    lab_cbrt_unit u_cbrt_x
    (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(v_m), .t_in(tm_x),
        .v_out(v_cx), .t_out(tc_x), .f_out(c_x)
    );

    lab_cbrt_unit u_cbrt_y
    (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(v_m), .t_in(tm_y),
        .v_out(v_cy), .t_out(tc_y), .f_out(c_y)
    );

    lab_cbrt_unit u_cbrt_z
    (
        .clk(clk), .rst_n(rst_n), .en(en), .v_in(v_m), .t_in(tm_z),
        .v_out(v_cz), .t_out(tc_z), .f_out(c_z)
    );

    lab_finish #(.FRAC_BITS(FRAC_BITS)) u_finish
    (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .v_in(v_all),
        .t_x(tc_x),
        .t_y(tc_y),
        .t_z(tc_z),
        .c_x(c_x),
        .c_y(c_y),
        .c_z(c_z),
        .v_out(out_valid),
        .lightness(lightness),
        .green_red(green_red),
        .blue_yellow(blue_yellow)
    );

endmodule
`default_nettype wire

[src/lab_checker.sv]
`default_nettype none
module lab_checker
#(
    parameter int FRAC_BITS = 8
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [14:0] lightness,
    input wire logic [15:0] green_red,
    input wire logic [15:0] blue_yellow
);

    localparam int L_HI = ((100 << FRAC_BITS) < 32767) ? (100 << FRAC_BITS) : 32767;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(lightness)
        && $stable(green_red) && $stable(blue_yellow))
        else $error("held result item changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    a_l_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(lightness) <= 32'(L_HI))
        else $error("lightness out of range");

    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output empty");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_stall, out_valid}))
        else $error("handshake signal unknown");

endmodule

bind rgb_to_cielab_converter_unit lab_checker #(.FRAC_BITS(FRAC_BITS)) u_lab_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .lightness(lightness),
    .green_red(green_red),
    .blue_yellow(blue_yellow)
);
`default_nettype wire

[tb/rgb_to_cielab_checker.sv]
`timescale 1ns / 1ps
module rgb_to_cielab_checker
#(
    parameter int FRAC_BITS = 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [14:0]        lightness,
    input  wire logic signed [15:0] green_red,
    input  wire logic signed [15:0] blue_yellow,
    output int                      fail_count,
    output int                      pending_count
);

    typedef struct packed {
        logic [14:0]        l;
        logic signed [15:0] a;
        logic signed [15:0] b;
    } lab_t;

    localparam int OSH = 20 - FRAC_BITS;
    localparam longint unsigned THR = (64'd8856 << 20) / 64'd1000000;
    localparam longint unsigned K7 = (((64'd7787 << 17) / 64'd1000) + 64'd1) >> 1;
    localparam longint unsigned C16 = (((64'd16 << 21) / 64'd116) + 64'd1) >> 1;
    localparam longint unsigned K903 = (((64'd9033 << 17) / 64'd10) + 64'd1) >> 1;

    lab_t lab_queue[$];

    function automatic longint unsigned coef(longint unsigned m, longint unsigned w);
        return (((m << 21) / w) + 64'd1) >> 1;
    endfunction

    function automatic longint unsigned icbrt(longint unsigned n);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int k = 21; k >= 0; k--)
        begin
            c = r | (64'd1 << k);
            if (c < (64'd1 << 21) && c * c * c <= n)
                r = c;
        end
        return r;
    endfunction

    function automatic longint unsigned lab_curve(longint unsigned t);
        if (t > THR)
            return icbrt(t << 40);
        return ((K7 * t + (64'd1 << 15)) >> 16) + C16;
    endfunction

    function automatic longint round_q20(longint v);
        longint h;
        h = (OSH > 0) ? (longint'(1) << (OSH - 1)) : 0;
        return (v + h) >>> OSH;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic lab_t predict_lab(logic [7:0] r, logic [7:0] g, logic [7:0] bl);
        longint unsigned m[9];
        longint unsigned v[3];
        longint unsigned t[3];
        longint unsigned f[3];
        longint unsigned s;
        longint l;
        longint a;
        longint b;
        lab_t res;
        m[0] = coef(412453, 950456); m[1] = coef(357580, 950456);
        m[2] = coef(180423, 950456); m[3] = coef(212671, 1000000);
        m[4] = coef(715160, 1000000); m[5] = coef(72169, 1000000);
        m[6] = coef(19334, 1088754); m[7] = coef(119193, 1088754);
        m[8] = coef(950227, 1088754);
        v[0] = r; v[1] = g; v[2] = bl;
        for (int i = 0; i < 3; i++)
        begin
            s = m[3*i] * v[0] + m[3*i+1] * v[1] + m[3*i+2] * v[2];
            t[i] = (s + 127) / 255;
            f[i] = lab_curve(t[i]);
        end
        if (t[1] > THR)
            l = 116 * longint'(f[1]) - (longint'(16) << 20);
        else
            l = longint'((K903 * t[1] + (64'd1 << 15)) >> 16);
        a = 500 * (longint'(f[0]) - longint'(f[1]));
        b = 200 * (longint'(f[1]) - longint'(f[2]));
        l = sat(sat(round_q20(l), 0, longint'(100) << FRAC_BITS), 0, 32767);
        res.l = l[14:0];
        a = sat(round_q20(a), -32768, 32767);
        b = sat(round_q20(b), -32768, 32767);
        res.a = a[15:0];
        res.b = b[15:0];
        return res;
    endfunction

    assign pending_count = lab_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        lab_t exp_lab;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            fail_count <= 0;
            lab_queue.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                lab_queue.push_back(predict_lab(red, green, blue));
            if (out_valid && !out_stall)
            begin
                if (lab_queue.size() == 0)
                begin
                    $error("unexpected item: lightness %0d", lightness);
                    errs++;
                end
                else
                begin
                    exp_lab = lab_queue.pop_front();
                    if (lightness !== exp_lab.l)
                    begin
                        $error("lightness expected %0d actual %0d", exp_lab.l, lightness);
                        errs++;
                    end
                    if (green_red !== exp_lab.a)
                    begin
                        $error("green_red expected %0d actual %0d", exp_lab.a, green_red);
                        errs++;
                    end
                    if (blue_yellow !== exp_lab.b)
                    begin
                        $error("blue_yellow expected %0d actual %0d", exp_lab.b,
                               blue_yellow);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

[tb/tb_rgb_to_cielab_converter_unit.sv]
`timescale 1ns / 1ps
module tb_rgb_to_cielab_converter_unit;

    localparam int N_RANDOM = 1600;
    localparam int CYCLE_LIMIT = 200000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              out_valid;
    logic              out_stall;
    logic [14:0]       lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
    int                fail_count;
    int                pending_count;
    int                cycles;
    bit                quiet;

    rgb_to_cielab_converter_unit DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .red(red), .green(green), .blue(blue), .out_valid(out_valid),
        .out_stall(out_stall), .lightness(lightness), .green_red(green_red),
        .blue_yellow(blue_yellow)
    );

    rgb_to_cielab_checker CHK (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .red(red), .green(green), .blue(blue), .out_valid(out_valid),
        .out_stall(out_stall), .lightness(lightness), .green_red(green_red),
        .blue_yellow(blue_yellow), .fail_count(fail_count),
        .pending_count(pending_count)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver stalls in bursts of random length until the quiet tail.
    initial
    begin
        int n;
        out_stall = 0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 4);
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
        end
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int n;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 4);
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1;
        red <= r;
        green <= g;
        blue <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 6));
            1: return 8'($urandom_range(249, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    initial
    begin
        quiet = 0;
        rst_n = 0;
        in_valid = 0;
        red = 0;
        green = 0;
        blue = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        for (int k = 1; k <= 8; k++)
            send_pixel(8'(k), 8'(k), 8'(k));
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd170, 8'd85, 8'd170);
        send_pixel(8'd85, 8'd170, 8'd85);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - 200)
                quiet = 1;
            send_pixel(pick_level(), pick_level(), pick_level());
        end
        in_valid <= 0;
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
